[hdl/lppd_pkg.sv]
// Package for the length-prefixed phrase deframer.
// Holds the result kind codes, the result record and the result queue size.
// No dependencies.
package lppd_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [9:0] address;
    logic [7:0] data;
    logic [9:0] count;
    logic       last;
  } result_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

endpackage

[hdl/lppd_result_queue.sv]
// Result queue of the length-prefixed phrase deframer.
// Takes up to two results per cycle and hands out one per transfer.
// Depends on lppd_pkg.
module lppd_result_queue
  import lppd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push0,
  input  logic    push1,
  input  result_t entry0,
  input  result_t entry1,
  output logic    room,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t head_entry
);

  result_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    head;
  logic [QUEUE_AW-1:0]    tail;
  logic [QUEUE_AW:0]      fill;
  logic [QUEUE_AW:0]      fill_next;
  logic [QUEUE_AW-1:0]    push_n;
  logic                   pop;

  assign push_n     = QUEUE_AW'(push0) + QUEUE_AW'(push1);
  assign pop        = pop_valid && pop_ready;
  assign pop_valid  = (fill != '0);
  assign head_entry = slots[head];
  assign room       = (fill <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

  always_comb begin
    fill_next = fill + (QUEUE_AW+1)'(push_n) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head + QUEUE_AW'(pop);
      tail <= tail + push_n;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      slots[tail] <= entry0;
    end
    if (push1) begin
      slots[tail + QUEUE_AW'(1)] <= entry1;
    end
  end

endmodule

[hdl/length_prefixed_phrase_deframer.sv]
// Top level of the length-prefixed phrase deframer.
// Decodes received bytes into buffer writes, completion and error reports.
// Depends on lppd_pkg and lppd_result_queue.
//
//   channel   handshake                payload
//   input     in_valid / in_ready      rx_byte
//   output    out_valid / out_ready    kind, address, data, count, last
//   config    cfg_write                cfg_data (capacity)
//
// One byte is accepted per cycle while in_ready is high; its zero, one or two
// results enter a four-entry result queue in the same cycle and leave one per
// transfer. A result can appear on the output in the cycle after its byte is
// accepted. in_ready is high while the queue has room for two results, so a
// stalled output stops input only once two results wait behind it.
// Reset empties the queue, clears the phrase state and sets capacity to 1024.
module length_prefixed_phrase_deframer
  import lppd_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [9:0]  address,
  output logic [7:0]  data,
  output logic [9:0]  count,
  output logic        last,
  input  logic        cfg_write,
  input  logic [10:0] cfg_data
);

  localparam int unsigned LIMIT = (MAX_BYTES < 1024) ? MAX_BYTES : 1024;

  logic [10:0] capacity;
  logic        expect_header;
  logic [7:0]  phrase_length;
  logic [7:0]  phrase_position;
  logic [9:0]  fill_count;

  logic        expect_header_next;
  logic [7:0]  phrase_length_next;
  logic [7:0]  phrase_position_next;
  logic [9:0]  fill_count_next;

  logic [10:0] cap_use;
  logic        full;
  logic        at_end;
  logic        header;
  logic [9:0]  fill_mid;
  logic        v0;
  logic        v1;
  result_t     r0;
  result_t     r1;
  result_t     head_entry;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    cap_use = (capacity > 11'(LIMIT)) ? 11'(LIMIT) : capacity;
    full    = (({1'b0, fill_count} + 11'd1) >= cap_use);
    at_end  = (phrase_length != 8'd0) && (phrase_position == phrase_length - 8'd1);

    expect_header_next   = expect_header;
    phrase_length_next   = phrase_length;
    phrase_position_next = phrase_position;
    fill_count_next      = fill_count;
    header   = expect_header;
    fill_mid = fill_count;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = '0;
    r1 = '0;

    if (!expect_header) begin
      phrase_position_next = phrase_position + 8'd1;
      if (!at_end) begin
        if (!full) begin
          v0 = 1'b1;
          r0.kind    = KIND_WRITE;
          r0.address = fill_count;
          r0.data    = rx_byte;
          fill_count_next = fill_count + 10'd1;
          if (rx_byte == 8'd0) begin
            v1 = 1'b1;
            r1.kind  = KIND_ERROR;
            r1.count = fill_count + 10'd1;
            expect_header_next   = 1'b1;
            phrase_length_next   = 8'd0;
            phrase_position_next = 8'd0;
            fill_count_next      = 10'd0;
          end
        end
      end else begin
        if (!full) begin
          v0 = 1'b1;
          r0.kind    = KIND_WRITE;
          r0.address = fill_count;
          fill_mid   = fill_count + 10'd1;
        end
        header = 1'b1;
      end
    end

    if (header) begin
      expect_header_next   = 1'b0;
      phrase_length_next   = rx_byte;
      phrase_position_next = 8'd0;
      fill_count_next      = fill_mid;
      if (rx_byte == 8'd0) begin
        if (v0) begin
          v1 = 1'b1;
          r1.kind  = KIND_DONE;
          r1.count = fill_mid;
        end else begin
          v0 = 1'b1;
          r0.kind  = KIND_DONE;
          r0.count = fill_mid;
        end
        expect_header_next   = 1'b1;
        phrase_length_next   = 8'd0;
        fill_count_next      = 10'd0;
      end
    end

    if (v1) begin
      r1.last = 1'b1;
    end else begin
      r0.last = v0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= 11'd1024;
      expect_header   <= 1'b1;
      phrase_length   <= 8'd0;
      phrase_position <= 8'd0;
      fill_count      <= 10'd0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        expect_header   <= expect_header_next;
        phrase_length   <= phrase_length_next;
        phrase_position <= phrase_position_next;
        fill_count      <= fill_count_next;
      end
    end
  end

  lppd_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push0      (accept && v0),
    .push1      (accept && v1),
    .entry0     (r0),
    .entry1     (r1),
    .room       (in_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .head_entry (head_entry)
  );

  assign kind    = head_entry.kind;
  assign address = head_entry.address;
  assign data    = head_entry.data;
  assign count   = head_entry.count;
  assign last    = head_entry.last;

endmodule

[hdl/lppd_checker.sv]
// Port checker for the length-prefixed phrase deframer, bound to the top level.
// Watches the result channel and the reset behavior.
// Depends on lppd_pkg and length_prefixed_phrase_deframer.
module lppd_checker
  import lppd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [9:0] address,
  input logic [7:0] data,
  input logic [9:0] count,
  input logic       last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("Block not empty and ready after reset.");

  a_write_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_WRITE) |-> count == 10'd0)
    else $error("Buffer write carries a nonzero count.");

  a_report_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_WRITE) |-> address == 10'd0 && data == 8'd0 && last)
    else $error("Completion or error report has bad fields.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(kind) && $stable(address)
      && $stable(data) && $stable(count) && $stable(last))
    else $error("Stalled result changed.");

endmodule

bind length_prefixed_phrase_deframer lppd_checker u_lppd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .address   (address),
  .data      (data),
  .count     (count),
  .last      (last)
);

[tb/deframer_checker.sv]
// Checker for the length-prefixed phrase deframer. It watches the byte, result and
// configuration ports, predicts every result from its own copy of the phrase state
// and compares each transfer. Depends on lppd_pkg.
module deframer_checker
  import lppd_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [9:0]  address,
  input  logic [7:0]  data,
  input  logic [9:0]  count,
  input  logic        last,
  input  logic        cfg_write,
  input  logic [10:0] cfg_data,
  output int unsigned failures,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [10:0] capacity_reg;
  logic        header_due;
  logic [7:0]  phrase_len;
  logic [7:0]  phrase_pos;
  logic [9:0]  fill;
  result_t     expected_q[$];

  function automatic result_t pack_result(kind_t k, logic [9:0] a, logic [7:0] d,
                                          logic [9:0] c);
    result_t r;
    r.kind    = k;
    r.address = a;
    r.data    = d;
    r.count   = c;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic clear_phrase_state();
    header_due = 1'b1;
    phrase_len = 8'd0;
    phrase_pos = 8'd0;
    fill       = 10'd0;
  endtask

  task automatic report_mismatch(input string msg);
    failures++;
    $display("[%0t] deframer mismatch: %s", $time, msg);
  endtask

  task automatic predict_byte(input logic [7:0] b);
    int      limit;
    bit      full;
    bit      at_end;
    bit      take_header;
    result_t res[2];
    int      n;
    n = 0;
    limit = int'(capacity_reg);
    if (limit > int'(MAX_BYTES)) limit = int'(MAX_BYTES);
    if (limit > 1024) limit = 1024;
    take_header = header_due;
    if (!header_due) begin
      full   = !((int'(fill) + 1) < limit);
      at_end = (phrase_len != 8'd0) && (phrase_pos == phrase_len - 8'd1);
      phrase_pos = phrase_pos + 8'd1;
      if (at_end) begin
        if (!full) begin
          res[n] = pack_result(KIND_WRITE, fill, 8'd0, 10'd0);
          n++;
          fill = fill + 10'd1;
        end
        take_header = 1'b1;
      end else if (!full) begin
        res[n] = pack_result(KIND_WRITE, fill, b, 10'd0);
        n++;
        fill = fill + 10'd1;
        if (b == 8'd0) begin
          res[n] = pack_result(KIND_ERROR, 10'd0, 8'd0, fill);
          n++;
          clear_phrase_state();
        end
      end
    end
    if (take_header) begin
      phrase_len = b;
      header_due = 1'b0;
      phrase_pos = 8'd0;
      if (b == 8'd0) begin
        res[n] = pack_result(KIND_DONE, 10'd0, 8'd0, fill);
        n++;
        clear_phrase_state();
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    result_t exp;
    if (rst) begin
      capacity_reg = 11'd1024;
      clear_phrase_state();
      expected_q.delete();
      failures = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result kind %0d address %0d with none expected",
                                    kind, address));
        end else begin
          exp = expected_q.pop_front();
          if (kind !== exp.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, exp.kind));
          if (address !== exp.address)
            report_mismatch($sformatf("address %0d, expected %0d", address, exp.address));
          if (data !== exp.data)
            report_mismatch($sformatf("data %0h, expected %0h", data, exp.data));
          if (count !== exp.count)
            report_mismatch($sformatf("count %0d, expected %0d", count, exp.count));
          if (last !== exp.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, exp.last));
        end
      end
      if (cfg_write) capacity_reg = cfg_data;
      if (in_valid && in_ready) predict_byte(rx_byte);
    end
    outstanding <= expected_q.size();
  end

endmodule

[tb/testbench.sv]
// Top of the deframer testbench: clock, reset, byte traffic, result stalls and
// capacity writes across several phases, then the verdict.
// Depends on lppd_pkg, length_prefixed_phrase_deframer and deframer_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [9:0]  address;
  logic [7:0]  data;
  logic [9:0]  count;
  logic        last;
  logic        cfg_write;
  logic [10:0] cfg_data;

  int unsigned failures;
  int unsigned outstanding;
  int          idle_pct;
  int          stall_pct;
  int          hold_left;
  int          sent_bytes;

  length_prefixed_phrase_deframer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .address   (address),
    .data      (data),
    .count     (count),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  deframer_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .address     (address),
    .data        (data),
    .count       (count),
    .last        (last),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 200) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [10:0] value);
    wait_drained();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_message();
    int phrases;
    int len;
    phrases = $urandom_range(0, 4);
    for (int p = 0; p < phrases; p++) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_byte(8'(len));
      for (int k = 1; k < len; k++) begin
        if ($urandom_range(59) == 0) begin
          send_byte(8'h00);
          return;
        end
        if ($urandom_range(199) == 0) return;
        send_byte(8'($urandom_range(1, 255)));
      end
    end
    send_byte(8'h00);
  endtask

  task automatic random_traffic(input int n_bytes);
    int stop;
    stop = sent_bytes + n_bytes;
    while (sent_bytes < stop) begin
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
      else send_message();
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = 8'd0;
    out_ready  = 1'b0;
    cfg_write  = 1'b0;
    cfg_data   = 11'd0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_left  = 0;
    sent_bytes = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty message, empty phrase, terminator plus completion, data error,
    // extreme data values.
    directed = '{8'h00, 8'h01, 8'h03, 8'hFF, 8'h01, 8'h00,
                 8'h04, 8'h80, 8'h00, 8'h02, 8'h7F, 8'h00,
                 8'h03, 8'h55, 8'hAA, 8'h00, 8'h02, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);

    // One phrase of the largest length, with capacity clamped to 1024.
    write_capacity(11'd2047);
    send_byte(8'hFF);
    repeat (254) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'h00);

    write_capacity(11'd1024);
    random_traffic(100);

    write_capacity(11'd2);
    idle_pct = 86;
    random_traffic(70);

    write_capacity(11'd37);
    idle_pct  = 0;
    stall_pct = 86;
    @(posedge clk);
    hold_left = 400;
    random_traffic(110);

    write_capacity(11'd0);
    idle_pct  = 34;
    stall_pct = 34;
    random_traffic(40);

    write_capacity(11'd1);
    random_traffic(30);

    write_capacity(11'd5);
    random_traffic(40);
    wait_drained();
    random_traffic(40);

    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
